/* src/zseu_pkg.sv */
// ----------------------------------------------------------------------------
// zseu_pkg
// Shared types and constants for the Z80 subset execute unit: item
// layouts, register-file indexes, opcodes and flag bit positions.
// ----------------------------------------------------------------------------
package zseu_pkg;

  // One request: execute the instruction at PC, or an interrupt request.
  typedef struct packed {
    logic       req_type;
    logic [7:0] opcode;
    logic [7:0] imm_lo;
    logic [7:0] imm_hi;
    logic [7:0] rd_lo;
    logic [7:0] rd_hi;
  } in_item_t;

  // One result: architectural view after the step plus the memory write.
  typedef struct packed {
    logic [15:0] pc_next;
    logic [1:0]  wr_size;
    logic [15:0] wr_addr;
    logic [15:0] wr_data;
    logic [15:0] hl_now;
    logic [15:0] sp_now;
    logic [7:0]  acc_out;
    logic [7:0]  flags_out;
    logic [3:0]  tstates;
    logic        is_halted;
    logic        int_enabled;
    logic        unknown_op;
  } out_item_t;

  // Request kinds
  localparam logic REQ_EXEC = 1'b0;
  localparam logic REQ_INT  = 1'b1;

  // Write sizes
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_BYTE = 2'd1;
  localparam logic [1:0] WR_WORD = 2'd2;

  // Register file indexes
  localparam logic [2:0] IDX_B = 3'd0;
  localparam logic [2:0] IDX_C = 3'd1;
  localparam logic [2:0] IDX_D = 3'd2;
  localparam logic [2:0] IDX_E = 3'd3;
  localparam logic [2:0] IDX_H = 3'd4;
  localparam logic [2:0] IDX_L = 3'd5;
  localparam logic [2:0] IDX_F = 3'd6;
  localparam logic [2:0] IDX_A = 3'd7;
  localparam int unsigned NUM_GPR = 8;

  // Opcodes
  localparam logic [7:0] OP_NOP     = 8'h00;
  localparam logic [7:0] OP_LD_BC   = 8'h01;
  localparam logic [7:0] OP_LD_DE   = 8'h11;
  localparam logic [7:0] OP_LD_HL   = 8'h21;
  localparam logic [7:0] OP_LD_SP   = 8'h31;
  localparam logic [7:0] OP_LD_M_N  = 8'h36;
  localparam logic [7:0] OP_HALT    = 8'h76;
  localparam logic [7:0] OP_ADD_M   = 8'h86;
  localparam logic [7:0] OP_AND_N   = 8'hE6;
  localparam logic [7:0] OP_XOR_N   = 8'hEE;
  localparam logic [7:0] OP_JP      = 8'hC3;
  localparam logic [7:0] OP_RET     = 8'hC9;
  localparam logic [7:0] OP_DI      = 8'hF3;
  localparam logic [7:0] OP_EI      = 8'hFB;

  // Opcode groups (bits 7..6) and operand field codes
  localparam logic [1:0] GRP_MISC   = 2'b00;
  localparam logic [1:0] GRP_LD_RR  = 2'b01;
  localparam logic [2:0] REG_M      = 3'd6;   // (HL) operand
  localparam logic [2:0] REG_LAST_PAIR = 3'd5; // L, last of B..L

  // Constants
  localparam logic [15:0] SP_RESET   = 16'h2000;
  localparam logic [15:0] INT_VECTOR = 16'h0038;
  localparam logic [7:0]  FLAG_MASK  = 8'hD7;

  // T-state counts
  localparam logic [3:0] TS_NONE = 4'd0;
  localparam logic [3:0] TS_4    = 4'd4;
  localparam logic [3:0] TS_7    = 4'd7;
  localparam logic [3:0] TS_10   = 4'd10;
  localparam logic [3:0] TS_INT  = 4'd13;

  // Flag byte S Z - H - PV N C
  function automatic logic [7:0] pack_flags(logic [7:0] res, logic h, logic pv, logic c);
    pack_flags = {res[7], (res == 8'h00), 1'b0, h, 1'b0, pv, 1'b0, c};
  endfunction

endpackage

/* src/z80_subset_execute_unit.sv */
// ----------------------------------------------------------------------------
// z80_subset_execute_unit
// Executes one instruction or interrupt request per item for a small
// 8080-class subset and reports the resulting machine state.
// ----------------------------------------------------------------------------
// Usage: each input item is either an instruction step (opcode and operand
// bytes at PC, plus memory data read at HL, or at SP/SP+1 for RET) or a
// mode 1 interrupt request. Exactly one result item comes back per input
// item, in order. Throughput is one item per clock while the output is not
// stalled: the item sits in an input register, is decoded and executed by a
// single level of byte-wide logic against the architectural registers, and
// the result is captured in the output register while the state is updated
// in that same cycle, so the next item sees it immediately. The result
// becomes valid once the item has passed the input register and then the
// output register. A stalled output only stops the flow once both registers
// are full. The caller must present the bytes at the PC/HL/SP values given
// by the previous result. IFF2 is not kept since no result depends on it;
// EI takes effect at once. After reset: PC 0, SP 0x2000, all 8-bit
// registers zero, interrupts disabled, not halted.
module z80_subset_execute_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  zseu_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output zseu_pkg::out_item_t out_item
);
  import zseu_pkg::*;

  // Input stage
  logic     s_valid;
  in_item_t s_item;

  // Output stage
  logic      o_valid;
  out_item_t o_item;

  // Architectural state
  logic [7:0]  gpr [NUM_GPR];
  logic [15:0] sp;
  logic [15:0] pc;
  logic        ie;       // IFF1
  logic        halted;

  logic [7:0]  gpr_next [NUM_GPR];
  logic [15:0] sp_next;
  logic [15:0] pc_next;
  logic        ie_next;
  logic        halted_next;
  out_item_t   res;

  logic advance;

  // Stage moves forward whenever the output register is free or draining.
  assign advance   = s_valid && (!o_valid || out_ready);
  assign in_ready  = !s_valid || advance;
  assign out_valid = o_valid;
  assign out_item  = o_item;

  // Execute: decode plus byte ALU against current state
  logic [7:0]  op;
  logic [2:0]  dst;
  logic [2:0]  src;
  logic [7:0]  acc;
  logic [7:0]  rlo;
  logic [7:0]  alu;
  logic [8:0]  sum9;
  logic [4:0]  half;
  logic [15:0] hl;
  logic [1:0]  len;
  logic        jumped;

  always_comb begin
    op   = s_item.opcode;
    dst  = op[5:3];
    src  = op[2:0];
    acc  = gpr[IDX_A];
    rlo  = s_item.rd_lo;
    hl   = {gpr[IDX_H], gpr[IDX_L]};
    sum9 = {1'b0, acc} + {1'b0, rlo};
    half = {1'b0, acc[3:0]} + {1'b0, rlo[3:0]};
    alu  = 8'h00;

    for (int i = 0; i < NUM_GPR; i++) begin
      gpr_next[i] = gpr[i];
    end
    sp_next     = sp;
    pc_next     = pc;
    ie_next     = ie;
    halted_next = halted;
    len         = 2'd1;
    jumped      = 1'b0;
    res         = '0;
    res.wr_size = WR_NONE;
    res.tstates = TS_NONE;

    if (s_item.req_type == REQ_INT) begin
      // Mode 1 interrupt; refused silently while disabled
      if (ie) begin
        ie_next     = 1'b0;
        halted_next = 1'b0;
        sp_next     = sp - 16'd2;
        res.wr_size = WR_WORD;
        res.wr_addr = sp - 16'd2;
        res.wr_data = pc;
        pc_next     = INT_VECTOR;
        res.tstates = TS_INT;
      end
    end else if (halted) begin
      res.tstates = TS_4;
    end else begin
      res.tstates = TS_4;
      if (op[7:6] == GRP_LD_RR) begin
        // 8-bit register/memory moves, and HALT
        priority if (op == OP_HALT) begin
          halted_next = 1'b1;
        end else if (src == REG_M) begin
          gpr_next[dst] = rlo;
          res.tstates   = TS_7;
        end else if (dst == REG_M) begin
          res.wr_size = WR_BYTE;
          res.wr_addr = hl;
          res.wr_data = {8'h00, gpr[src]};
          res.tstates = TS_7;
        end else if (src <= REG_LAST_PAIR) begin
          gpr_next[dst] = gpr[src];
        end else begin
          res.unknown_op = 1'b1;  // source A is not supported
        end
      end else if (op[7:6] == GRP_MISC && src == REG_M && dst != REG_M) begin
        // LD r,n
        gpr_next[dst] = s_item.imm_lo;
        len           = 2'd2;
        res.tstates   = TS_7;
      end else begin
        unique case (op)
          OP_NOP: ;
          OP_LD_BC: begin
            gpr_next[IDX_C] = s_item.imm_lo;
            gpr_next[IDX_B] = s_item.imm_hi;
            len = 2'd3;
            res.tstates = TS_10;
          end
          OP_LD_DE: begin
            gpr_next[IDX_E] = s_item.imm_lo;
            gpr_next[IDX_D] = s_item.imm_hi;
            len = 2'd3;
            res.tstates = TS_10;
          end
          OP_LD_HL: begin
            gpr_next[IDX_L] = s_item.imm_lo;
            gpr_next[IDX_H] = s_item.imm_hi;
            len = 2'd3;
            res.tstates = TS_10;
          end
          OP_LD_SP: begin
            sp_next = {s_item.imm_hi, s_item.imm_lo};
            len = 2'd3;
            res.tstates = TS_10;
          end
          OP_LD_M_N: begin
            res.wr_size = WR_BYTE;
            res.wr_addr = hl;
            res.wr_data = {8'h00, s_item.imm_lo};
            len = 2'd2;
            res.tstates = TS_10;
          end
          OP_ADD_M: begin
            alu = sum9[7:0];
            gpr_next[IDX_A] = alu;
            gpr_next[IDX_F] = pack_flags(alu, half[4],
                                         ~(acc[7] ^ rlo[7]) & (acc[7] ^ sum9[7]),
                                         sum9[8]);
            res.tstates = TS_7;
          end
          OP_AND_N: begin
            alu = acc & s_item.imm_lo;
            gpr_next[IDX_A] = alu;
            gpr_next[IDX_F] = pack_flags(alu, 1'b1, ~^alu, 1'b0);
            len = 2'd2;
            res.tstates = TS_7;
          end
          OP_XOR_N: begin
            alu = acc ^ s_item.imm_lo;
            gpr_next[IDX_A] = alu;
            gpr_next[IDX_F] = pack_flags(alu, 1'b0, ~^alu, 1'b0);
            len = 2'd2;
            res.tstates = TS_7;
          end
          OP_JP: begin
            pc_next = {s_item.imm_hi, s_item.imm_lo};
            jumped  = 1'b1;
            res.tstates = TS_10;
          end
          OP_RET: begin
            pc_next = {s_item.rd_hi, s_item.rd_lo};
            sp_next = sp + 16'd2;
            jumped  = 1'b1;
            res.tstates = TS_10;
          end
          OP_DI: ie_next = 1'b0;
          OP_EI: ie_next = 1'b1;
          default: res.unknown_op = 1'b1;  // skipped as a one-byte no-op
        endcase
      end
      if (!jumped) begin
        pc_next = pc + {14'd0, len};
      end
    end

    res.pc_next     = pc_next;
    res.hl_now      = {gpr_next[IDX_H], gpr_next[IDX_L]};
    res.sp_now      = sp_next;
    res.acc_out     = gpr_next[IDX_A];
    res.flags_out   = gpr_next[IDX_F] & FLAG_MASK;
    res.is_halted   = halted_next;
    res.int_enabled = ie_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      o_valid <= 1'b0;
      for (int i = 0; i < NUM_GPR; i++) begin
        gpr[i] <= 8'h00;
      end
      sp     <= SP_RESET;
      pc     <= 16'h0000;
      ie     <= 1'b0;
      halted <= 1'b0;
    end else begin
      if (in_ready) begin
        s_valid <= in_valid;
      end
      if (advance) begin
        o_valid <= 1'b1;
        for (int i = 0; i < NUM_GPR; i++) begin
          gpr[i] <= gpr_next[i];
        end
        sp     <= sp_next;
        pc     <= pc_next;
        ie     <= ie_next;
        halted <= halted_next;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_item <= in_item;
    end
    if (advance) begin
      o_item <= res;
    end
  end

`ifndef SYNTHESIS
  // Architectural state only moves when an item is retired to the output.
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(pc) && $stable(sp) && $stable(ie) && $stable(halted))
    else $error("state changed without a retired item");

  // A result with no write carries zero address and data.
  assert property (@(posedge clk) disable iff (rst)
    o_valid && o_item.wr_size == WR_NONE |-> o_item.wr_addr == 16'h0000 &&
      o_item.wr_data == 16'h0000)
    else $error("write fields set without a write");

  // Only a taken interrupt costs 13 states; it vectors and disables.
  assert property (@(posedge clk) disable iff (rst)
    o_valid && o_item.tstates == TS_INT |-> o_item.pc_next == INT_VECTOR &&
      !o_item.int_enabled && !o_item.is_halted && o_item.wr_size == WR_WORD)
    else $error("interrupt result inconsistent");

  // Unsupported opcodes are one-byte no-ops.
  assert property (@(posedge clk) disable iff (rst)
    o_valid && o_item.unknown_op |-> o_item.tstates == TS_4 &&
      o_item.wr_size == WR_NONE)
    else $error("unknown opcode had side effects");

  // A retired item reaches the output register on the next edge.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> o_valid && o_item.sp_now == sp && o_item.pc_next == pc)
    else $error("result does not match committed state");
`endif

endmodule
